[hw/rtl/itpc_pkg.sv]
package itpc_pkg;

  localparam int STACK_DEPTH_DEF = 32;
  localparam int CHAR_W          = 8;

  localparam logic [CHAR_W-1:0] CH_CARET  = 8'h5E; // '^'
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28; // '('
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29; // ')'
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B; // '+'
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D; // '-'
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A; // '*'
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F; // '/'

  // Microprogram step addresses.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_EMIT,
    S_PUSH,
    S_OP,
    S_CLOSE,
    S_FLUSH,
    S_DONE,
    S_FINISH
  } step_t;

  // Datapath action selected by one control word.
  typedef enum logic [3:0] {
    A_ACCEPT,
    A_DISPATCH,
    A_EMIT_CHAR,
    A_PUSH,
    A_OP_LOOP,
    A_CLOSE_LOOP,
    A_FLUSH_LOOP,
    A_EMIT_DONE,
    A_FINISH
  } action_t;

  // Control word: action, and the step to jump to when the action completes.
  typedef struct packed {
    action_t action;
    step_t   target;
  } ctrl_t;

  // One result before its last-of-run mark is known.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              done;
    logic              ovf;
    logic              unm;
  } res_t;

  function automatic ctrl_t ucode(input step_t pc);
    ctrl_t w;
    case (pc)
      S_IDLE:     w = '{action: A_ACCEPT,     target: S_DISPATCH};
      S_DISPATCH: w = '{action: A_DISPATCH,   target: S_IDLE};
      S_EMIT:     w = '{action: A_EMIT_CHAR,  target: S_FINISH};
      S_PUSH:     w = '{action: A_PUSH,       target: S_FINISH};
      S_OP:       w = '{action: A_OP_LOOP,    target: S_PUSH};
      S_CLOSE:    w = '{action: A_CLOSE_LOOP, target: S_FINISH};
      S_FLUSH:    w = '{action: A_FLUSH_LOOP, target: S_DONE};
      S_DONE:     w = '{action: A_EMIT_DONE,  target: S_FINISH};
      S_FINISH:   w = '{action: A_FINISH,     target: S_IDLE};
      default:    w = '{action: A_FINISH,     target: S_IDLE};
    endcase
    return w;
  endfunction

  // Precedence level: 0 stands for "none" (below '+'), then 1..3.
  function automatic logic [1:0] prec(input logic [CHAR_W-1:0] c);
    logic [1:0] p;
    if (c == CH_CARET) begin
      p = 2'd3;
    end else if (c == CH_STAR || c == CH_SLASH) begin
      p = 2'd2;
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      p = 2'd1;
    end else begin
      p = 2'd0;
    end
    return p;
  endfunction

  function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39);
  endfunction

endpackage

[hw/rtl/itpc_ram.sv]
module itpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/infix_to_postfix_converter_unit.sv]
// Shunting-yard infix to postfix converter. Each input beat carries one
// infix character (s_tdata[7:0]) or, with s_tlast high, the end of the
// expression. Letters and digits come straight out; '(' is stacked; ')'
// pops operators up to the matching '(' and drops it; any other character
// pops every stacked entry of equal or higher precedence ('^' over '*' '/'
// over '+' '-', all else lowest) and is then stacked. An end beat flushes
// the stack and closes with a done beat (m_tuser high, character zero)
// that reports the sticky overflow and unmatched-')' flags, which then
// clear. m_tlast marks the last output beat caused by each input beat.
// A small microprogram sequences the work over a plain datapath and a
// STACK_DEPTH-entry operator stack RAM with registered read; one item is
// processed at a time. An operator beat pushes after its pop loop, and an
// end beat emits its done result after the flush. The pop loop takes one
// stack read per cycle while the output takes results; stalls hold it.
// A full stack drops the push and sets the overflow flag; a ')' with no
// '(' empties the stack and sets the unmatched flag.
module infix_to_postfix_converter_unit #(
  parameter int STACK_DEPTH = itpc_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_char
  input  logic        s_tlast,   // end_of_expr
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_char, [8] overflow_seen,
                                 // [9] unmatched_seen, [15:10] zero
  output logic        m_tuser,   // is_done
  output logic        m_tlast    // last_of_run
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  // Sequencer
  itpc_pkg::step_t pc, pc_next;
  itpc_pkg::ctrl_t ctrl;

  // Current item
  logic [7:0] cur_char;
  logic       cur_end;

  // Stack control and sticky flags
  logic [CW-1:0] count, count_next;
  logic          ovf, ovf_next;
  logic          unm, unm_next;

  // Stack RAM port
  logic          we;
  logic [AW-1:0] raddr;
  logic [CW-1:0] raddr_full;
  logic [7:0]    rdata;

  // Hold stage: keeps the newest result until we know if it ends the run
  itpc_pkg::res_t hold, emit_res;
  logic           hold_valid, hold_valid_next;
  logic           emit_req;

  // Output register
  itpc_pkg::res_t out_res;
  logic           out_last, out_valid, out_valid_next;
  logic           out_load, out_load_last;
  logic           out_free, can_emit;

  logic [1:0] cur_prec, top_prec;

  assign ctrl     = itpc_pkg::ucode(pc);
  assign out_free = !out_valid || m_tready;
  assign can_emit = !hold_valid || out_free;
  assign cur_prec = itpc_pkg::prec(cur_char);
  assign top_prec = itpc_pkg::prec(rdata);
  assign s_tready = (ctrl.action == itpc_pkg::A_ACCEPT);

  // Read the entry that will be on top next cycle, so rdata shows the top of
  // stack whenever count did not just change through a push.
  assign raddr_full = count_next - CW'(1);
  assign raddr      = (count_next == '0) ? '0 : raddr_full[AW-1:0];

  itpc_ram #(
    .WIDTH (8),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (count[AW-1:0]),
    .wdata (cur_char),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    pc_next    = pc;
    count_next = count;
    ovf_next   = ovf;
    unm_next   = unm;
    we         = 1'b0;
    emit_req   = 1'b0;
    emit_res   = '{ch: rdata, done: 1'b0, ovf: 1'b0, unm: 1'b0};
    out_load      = 1'b0;
    out_load_last = 1'b0;
    hold_valid_next = hold_valid;

    case (ctrl.action)
      itpc_pkg::A_ACCEPT: begin
        if (s_tvalid) begin
          pc_next = ctrl.target;
        end
      end
      itpc_pkg::A_DISPATCH: begin
        // Multiway jump on the character class
        if (cur_end) begin
          pc_next = itpc_pkg::S_FLUSH;
        end else if (itpc_pkg::is_alnum(cur_char)) begin
          pc_next = itpc_pkg::S_EMIT;
        end else if (cur_char == itpc_pkg::CH_LPAREN) begin
          pc_next = itpc_pkg::S_PUSH;
        end else if (cur_char == itpc_pkg::CH_RPAREN) begin
          pc_next = itpc_pkg::S_CLOSE;
        end else begin
          pc_next = itpc_pkg::S_OP;
        end
      end
      itpc_pkg::A_EMIT_CHAR: begin
        emit_res = '{ch: cur_char, done: 1'b0, ovf: 1'b0, unm: 1'b0};
        if (can_emit) begin
          emit_req = 1'b1;
          pc_next  = ctrl.target;
        end
      end
      itpc_pkg::A_PUSH: begin
        if (count >= CW'(STACK_DEPTH)) begin
          ovf_next = 1'b1;
        end else begin
          we         = 1'b1;
          count_next = count + CW'(1);
        end
        pc_next = ctrl.target;
      end
      itpc_pkg::A_OP_LOOP: begin
        if (count != '0 && cur_prec <= top_prec) begin
          if (can_emit) begin
            emit_req   = 1'b1;
            count_next = count - CW'(1);
          end
        end else begin
          pc_next = ctrl.target;
        end
      end
      itpc_pkg::A_CLOSE_LOOP: begin
        if (count == '0) begin
          unm_next = 1'b1;
          pc_next  = ctrl.target;
        end else if (rdata != itpc_pkg::CH_LPAREN) begin
          if (can_emit) begin
            emit_req   = 1'b1;
            count_next = count - CW'(1);
          end
        end else begin
          // Drop the matching '('
          count_next = count - CW'(1);
          pc_next    = ctrl.target;
        end
      end
      itpc_pkg::A_FLUSH_LOOP: begin
        if (count != '0) begin
          if (can_emit) begin
            emit_req   = 1'b1;
            count_next = count - CW'(1);
          end
        end else begin
          pc_next = ctrl.target;
        end
      end
      itpc_pkg::A_EMIT_DONE: begin
        emit_res = '{ch: 8'h00, done: 1'b1, ovf: ovf, unm: unm};
        if (can_emit) begin
          emit_req = 1'b1;
          ovf_next = 1'b0;
          unm_next = 1'b0;
          pc_next  = ctrl.target;
        end
      end
      itpc_pkg::A_FINISH: begin
        // Release the held result as the last beat of this run
        if (!hold_valid) begin
          pc_next = ctrl.target;
        end else if (out_free) begin
          out_load        = 1'b1;
          out_load_last   = 1'b1;
          hold_valid_next = 1'b0;
          pc_next         = ctrl.target;
        end
      end
      default: begin
        pc_next = itpc_pkg::S_IDLE;
      end
    endcase

    // A new result pushes the held one out, which therefore is not last
    if (emit_req) begin
      if (hold_valid) begin
        out_load      = 1'b1;
        out_load_last = 1'b0;
      end
      hold_valid_next = 1'b1;
    end

    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc         <= itpc_pkg::S_IDLE;
      count      <= '0;
      ovf        <= 1'b0;
      unm        <= 1'b0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      pc         <= pc_next;
      count      <= count_next;
      ovf        <= ovf_next;
      unm        <= unm_next;
      hold_valid <= hold_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cur_char <= s_tdata;
      cur_end  <= s_tlast;
    end
    if (emit_req) begin
      hold <= emit_res;
    end
    if (out_load) begin
      out_res  <= hold;
      out_last <= out_load_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, out_res.unm, out_res.ovf, out_res.ch};
  assign m_tuser  = out_res.done;
  assign m_tlast  = out_last;

  // Stack occupancy never exceeds its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("stack count above depth");

  // A new item is taken only once the previous run is fully released
  a_hold_drained: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !hold_valid)
    else $error("item accepted with a result still held");

  // A done beat always closes its run
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("done beat without last mark");

  // A held result is never overwritten while the output cannot take it
  a_no_clobber: assert property (@(posedge clk) disable iff (rst)
    (emit_req && hold_valid) |-> out_free)
    else $error("held result lost");

endmodule
